// File: sv/byte_bigram_frequency_scorer_defines.svh
// assertion macros for the byte bigram frequency scorer
// used by the controller; no other dependencies
`ifndef BYTE_BIGRAM_FREQUENCY_SCORER_DEFINES_SVH
`define BYTE_BIGRAM_FREQUENCY_SCORER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BBFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define BBFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bbfs_pkg.sv
// shared types, constants and helpers of the byte bigram frequency scorer
// no dependencies
package bbfs_pkg;

   localparam int DEF_ALPHABET_SIZE = 256;
   localparam int DEF_COUNT_WIDTH   = 32;

   localparam int TOTAL_WIDTH = 48;
   localparam int FRAC_WIDTH  = 49;
   localparam int ROOT_WIDTH  = 50;
   localparam int DIV_STEPS   = 48;
   localparam int SQRT_STEPS  = 25;
   localparam int ITER_WIDTH  = 6;
   localparam int SCORE_WIDTH = 18;
   localparam int DIFF_WIDTH  = 27;

   typedef enum logic [1:0] {
      CMD_BEGIN        = 2'd0,
      CMD_COUNT        = 2'd1,
      CMD_QUERY_SINGLE = 2'd2,
      CMD_QUERY_PAIR   = 2'd3
   } command_type;

   typedef struct packed {
      command_type command;
      logic        corpus;
      logic [7:0]  byte_value;
      logic [7:0]  first_byte;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_WIDTH-1:0] score;
      logic                          status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_WR,
      ST_Q_RD,
      ST_DIV,
      ST_SQRT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic cnt_wr;
      logic q_load;
      logic div_step;
      logic sqrt_step;
      logic load_out;
   } ctl_type;

   typedef struct packed {
      logic clr_last;
   } sts_type;

   function automatic logic is_usable(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             b == 8'h20 || b >= 8'h80;
   endfunction

endpackage

// File: sv/bbfs_ctrl.sv
// controller state machine of the byte bigram frequency scorer
// depends on bbfs_pkg and byte_bigram_frequency_scorer_defines.svh
`include "byte_bigram_frequency_scorer_defines.svh"
module bbfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  bbfs_pkg::req_type req,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bbfs_pkg::sts_type sts,
   output bbfs_pkg::ctl_type ctl
);
   import bbfs_pkg::*;

   state_type             state_ff, state_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               unique case (req.command)
                  CMD_BEGIN:        state_in = ST_IDLE;
                  CMD_COUNT:        state_in = ST_CNT_WR;
                  CMD_QUERY_SINGLE,
                  CMD_QUERY_PAIR:   state_in = ST_Q_RD;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_CNT_WR: begin
            ctl.cnt_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_Q_RD: begin
            ctl.q_load = 1'b1;
            iter_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == ITER_WIDTH'(DIV_STEPS - 1)) begin
               iter_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            ctl.sqrt_step = 1'b1;
            iter_in       = iter_ff + 1'b1;
            if (iter_ff == ITER_WIDTH'(SQRT_STEPS - 1)) begin
               iter_in  = '0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BBFS_ASSERT_IMPLY(a_load_free, clock, reset, ctl.load_out,
      !rsp_valid_ff || !rsp_stall, "result loaded over a waiting word")
   `BBFS_ASSERT_NEXT(a_count_write, clock, reset,
      state_ff == ST_IDLE && req_valid && req.command == CMD_COUNT,
      state_ff == ST_CNT_WR, "count word not followed by write-back")
   `BBFS_ASSERT_IMPLY(a_div_bound, clock, reset, state_ff == ST_DIV,
      iter_ff < ITER_WIDTH'(DIV_STEPS), "divide step count out of range")
   `BBFS_ASSERT_IMPLY(a_sqrt_bound, clock, reset, state_ff == ST_SQRT,
      iter_ff < ITER_WIDTH'(SQRT_STEPS), "root step count out of range")

endmodule

// File: sv/bbfs_datapath.sv
// count memories, totals, divider and square root lanes of the scorer
// depends on bbfs_pkg
module bbfs_datapath #(
   parameter int ALPHABET_SIZE = bbfs_pkg::DEF_ALPHABET_SIZE,
   parameter int COUNT_WIDTH   = bbfs_pkg::DEF_COUNT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  bbfs_pkg::req_type req,
   input  bbfs_pkg::ctl_type ctl,
   output bbfs_pkg::sts_type sts,
   output bbfs_pkg::rsp_type rsp
);
   import bbfs_pkg::*;

   localparam int PAIR_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
   localparam int AW         = $clog2(ALPHABET_SIZE);
   localparam int PW         = $clog2(PAIR_DEPTH);

   // clearing pass address
   logic [PW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (ctl.clear) clr_ff <= clr_ff + 1'b1;
   end
   assign sts.clr_last = (clr_ff == PW'(PAIR_DEPTH - 1));

   // latched word and its addresses
   req_type       item_ff;
   logic [AW-1:0] saddr_ff;
   logic [PW-1:0] paddr_ff;
   logic [7:0]    pbyte_ff;
   logic [7:0]    prev_ff [2];

   logic [AW-1:0] b_idx;
   logic [7:0]    prev_sel;
   logic [PW-1:0] raddr_p [2];

   assign b_idx    = req.byte_value[AW-1:0];
   assign prev_sel = prev_ff[req.corpus];

   for (genvar g = 0; g < 2; g++) begin : g_addr
      logic [7:0] row;
      assign row = (req.command == CMD_COUNT) ? prev_ff[g] : req.first_byte;
      assign raddr_p[g] = PW'(row[AW-1:0]) * PW'(ALPHABET_SIZE) + PW'(b_idx);
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         item_ff  <= req;
         saddr_ff <= b_idx;
         paddr_ff <= raddr_p[req.corpus];
         pbyte_ff <= prev_sel;
      end
   end

   logic count_ok, pair_ok, single_use;
   assign count_ok   = {1'b0, item_ff.byte_value} < 9'(ALPHABET_SIZE);
   assign single_use = is_usable(item_ff.byte_value);
   assign pair_ok    = (is_usable(pbyte_ff) || single_use) &&
                       ({1'b0, pbyte_ff} < 9'(ALPHABET_SIZE));

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
      end else if (ctl.accept && req.command == CMD_BEGIN) begin
         prev_ff[req.corpus] <= '0;
      end else if (ctl.cnt_wr && count_ok) begin
         prev_ff[item_ff.corpus] <= item_ff.byte_value;
      end
   end

   // count memories, one pair per corpus
   logic [COUNT_WIDTH-1:0] srd [2];
   logic [COUNT_WIDTH-1:0] prd [2];
   logic [TOTAL_WIDTH-1:0] stot_ff [2];
   logic [TOTAL_WIDTH-1:0] ptot_ff [2];

   for (genvar g = 0; g < 2; g++) begin : g_mem
      logic [COUNT_WIDTH-1:0] smem [ALPHABET_SIZE];
      logic [COUNT_WIDTH-1:0] pmem [PAIR_DEPTH];
      logic                   wr_this, s_we, p_we;
      logic [COUNT_WIDTH-1:0] s_inc, p_inc;

      assign wr_this = ctl.cnt_wr && count_ok && (item_ff.corpus == 1'(g));
      assign s_we    = wr_this && single_use;
      assign p_we    = wr_this && pair_ok;
      assign s_inc   = (srd[g] == '1) ? srd[g] : srd[g] + 1'b1;
      assign p_inc   = (prd[g] == '1) ? prd[g] : prd[g] + 1'b1;

      always_ff @(posedge clock) begin
         if (ctl.clear) smem[clr_ff[AW-1:0]] <= '0;
         else if (s_we) smem[saddr_ff] <= s_inc;
         srd[g] <= smem[b_idx];
      end

      always_ff @(posedge clock) begin
         if (ctl.clear) pmem[clr_ff] <= '0;
         else if (p_we) pmem[paddr_ff] <= p_inc;
         prd[g] <= pmem[raddr_p[g]];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stot_ff[g] <= '0;
            ptot_ff[g] <= '0;
         end else begin
            if (s_we && stot_ff[g] != '1) stot_ff[g] <= stot_ff[g] + 1'b1;
            if (p_we && ptot_ff[g] != '1) ptot_ff[g] <= ptot_ff[g] + 1'b1;
         end
      end
   end

   // query lanes: restoring divide into q, then root taken out of q in place
   logic [FRAC_WIDTH-1:0] bit_ff;
   logic                  zero_ff;
   logic                  is_pair, q_idx_ok;
   logic [ROOT_WIDTH-1:0] root_ff [2];

   assign is_pair  = (item_ff.command == CMD_QUERY_PAIR);
   assign q_idx_ok = count_ok && (!is_pair ||
                     ({1'b0, item_ff.first_byte} < 9'(ALPHABET_SIZE)));

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [TOTAL_WIDTH-1:0] t_ff, rem_ff, t_sel;
      logic [FRAC_WIDTH-1:0]  q_ff, rem2;
      logic                   sat_ff, ge, sat;
      logic [COUNT_WIDTH-1:0] n_sel;
      logic [ROOT_WIDTH-1:0]  sum;
      localparam int CMPW = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;

      assign n_sel = !q_idx_ok ? '0 : (is_pair ? prd[g] : srd[g]);
      assign t_sel = is_pair ? ptot_ff[g] : stot_ff[g];
      assign sat   = CMPW'(n_sel) >= CMPW'(t_sel);
      assign rem2  = {rem_ff, 1'b0};
      assign ge    = rem2 >= {1'b0, t_ff};
      assign sum   = root_ff[g] + ROOT_WIDTH'(bit_ff);

      always_ff @(posedge clock) begin
         if (ctl.q_load) begin
            t_ff       <= t_sel;
            sat_ff     <= sat;
            rem_ff     <= TOTAL_WIDTH'(n_sel);
            q_ff       <= sat ? {1'b1, {(FRAC_WIDTH-1){1'b0}}} : '0;
            root_ff[g] <= '0;
         end else if (ctl.div_step && !sat_ff) begin
            rem_ff <= ge ? TOTAL_WIDTH'(rem2 - {1'b0, t_ff}) : rem2[TOTAL_WIDTH-1:0];
            q_ff   <= {q_ff[FRAC_WIDTH-2:0], ge};
         end else if (ctl.sqrt_step) begin
            if ({1'b0, q_ff} >= sum) begin
               q_ff       <= q_ff - sum[FRAC_WIDTH-1:0];
               root_ff[g] <= (root_ff[g] >> 1) + ROOT_WIDTH'(bit_ff);
            end else begin
               root_ff[g] <= root_ff[g] >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.q_load) begin
         bit_ff  <= {1'b1, {(FRAC_WIDTH-1){1'b0}}};
         zero_ff <= (is_pair ? (ptot_ff[0] == '0 || ptot_ff[1] == '0)
                             : (stot_ff[0] == '0 || stot_ff[1] == '0));
      end else if (ctl.sqrt_step) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   // rounded difference, truncated toward zero
   logic signed [DIFF_WIDTH-1:0] diff, rnd, mag, res;
   assign diff = $signed({2'b00, root_ff[1][24:0]}) - $signed({2'b00, root_ff[0][24:0]});
   assign rnd  = diff + DIFF_WIDTH'(128);
   assign mag  = rnd[DIFF_WIDTH-1] ? -rnd : rnd;
   assign res  = rnd[DIFF_WIDTH-1] ? -(mag >>> 8) : (mag >>> 8);

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_ff.score  <= zero_ff ? '0 : res[SCORE_WIDTH-1:0];
         rsp_ff.status <= zero_ff;
      end
   end
   assign rsp = rsp_ff;

endmodule

// File: sv/byte_bigram_frequency_scorer.sv
// byte bigram frequency scorer, top level
// depends on bbfs_pkg, bbfs_ctrl and bbfs_datapath
//
// Input words carry a command: begin corpus, count byte, query single byte
// or query byte pair. Only queries produce a result word (score, status).
// After reset a clearing pass zeroes the count memories, one pair-memory
// address per cycle, over all ALPHABET_SIZE*ALPHABET_SIZE of them (65536 by
// default); req_stall stays high during it.
// Begin corpus is taken in the idle state; count byte does a memory read,
// then write-back of the bumped count.
// A query does one memory read, 48 steps of the restoring divider and 25
// steps of the square root, run for both corpora side by side, and then
// rounds into the output register.
// One word is worked on at a time. A finished result sits in the output
// register while the next word is accepted; if the receiver stalls, a
// following query waits in its last step until the register is taken.
module byte_bigram_frequency_scorer #(
   parameter int ALPHABET_SIZE = bbfs_pkg::DEF_ALPHABET_SIZE,
   parameter int COUNT_WIDTH   = bbfs_pkg::DEF_COUNT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bbfs_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbfs_pkg::rsp_type rsp
);
   import bbfs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   bbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   bbfs_datapath #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .ctl   (ctl),
      .sts   (sts),
      .rsp   (rsp)
   );

endmodule
